@@ rtl/gha_pkg.sv @@
package gha_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int GEN_BITS_DEF = 8;

   typedef enum logic [1:0] {
      REQ_CREATE = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_READ   = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_LINK,
      ST_POP_NEXT,
      ST_POP_GEN,
      ST_READ_DATA,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/gha_ram.sv @@
module gha_ram
   import gha_pkg::*;
#(
   parameter int DEPTH  = CAPACITY_DEF,
   parameter int WORD_W = $clog2(CAPACITY_DEF) + GEN_BITS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WORD_W-1:0] wr_data,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/gha_ctrl.sv @@
module gha_ctrl
   import gha_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int GEN_BITS = GEN_BITS_DEF,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1),
   localparam int WORD_W = IDX_W + GEN_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [GEN_BITS-1:0] req_slot_generation,
   output logic                mem_wr_en,
   output logic                mem_rd_en,
   output logic [IDX_W-1:0]    mem_addr,
   output logic [WORD_W-1:0]   mem_wr_data,
   input  logic [WORD_W-1:0]   mem_rd_data,
   output logic                res_valid,
   input  logic                res_ready,
   output logic [IDX_W-1:0]    res_index,
   output logic [GEN_BITS-1:0] res_generation,
   output logic [1:0]          res_status,
   output logic [CNT_W-1:0]    res_free_slots
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    slots_used_ff, slots_used_in;
   logic [CNT_W-1:0]    free_count_ff, free_count_in;
   logic [IDX_W-1:0]    head_idx_ff, head_idx_in;
   logic [GEN_BITS-1:0] head_gen_ff, head_gen_in;
   logic                head_valid_ff, head_valid_in;
   logic [IDX_W-1:0]    next_idx_ff, next_idx_in;
   logic [IDX_W-1:0]    res_idx_ff, res_idx_in;
   logic [GEN_BITS-1:0] res_gen_ff, res_gen_in;
   status_type          res_status_ff, res_status_in;

   logic [IDX_W-1:0]    rd_link;
   logic [GEN_BITS-1:0] rd_gen;
   logic [GEN_BITS-1:0] head_gen_inc;
   logic [CNT_W-1:0]    count_dec;
   logic                idx_in_range;

   assign rd_link      = mem_rd_data[WORD_W-1:GEN_BITS];
   assign rd_gen       = mem_rd_data[GEN_BITS-1:0];
   assign head_gen_inc = head_gen_ff + GEN_BITS'(1);
   assign count_dec    = free_count_ff - CNT_W'(1);
   assign idx_in_range = CNT_W'(req_slot_index) < slots_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slots_used_ff <= '0;
         free_count_ff <= '0;
         head_idx_ff   <= '0;
         head_gen_ff   <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slots_used_ff <= slots_used_in;
         free_count_ff <= free_count_in;
         head_idx_ff   <= head_idx_in;
         head_gen_ff   <= head_gen_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_idx_ff   <= next_idx_in;
      res_idx_ff    <= res_idx_in;
      res_gen_ff    <= res_gen_in;
      res_status_ff <= res_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      slots_used_in = slots_used_ff;
      free_count_in = free_count_ff;
      head_idx_in   = head_idx_ff;
      head_gen_in   = head_gen_ff;
      head_valid_in = head_valid_ff;
      next_idx_in   = next_idx_ff;
      res_idx_in    = res_idx_ff;
      res_gen_in    = res_gen_ff;
      res_status_in = res_status_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_addr      = head_idx_ff;
      mem_wr_data   = '0;
      req_stall     = 1'b1;
      res_valid     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               res_idx_in    = '0;
               res_gen_in    = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_FINISH;
               unique case (req_code_type'(req_type))
                  REQ_CREATE: begin
                     if (head_valid_ff && free_count_ff != '0) begin
                        mem_rd_en = 1'b1;
                        mem_addr  = head_idx_ff;
                        state_in  = ST_POP_LINK;
                     end else if (slots_used_ff < CNT_W'(CAPACITY)) begin
                        mem_wr_en     = 1'b1;
                        mem_addr      = slots_used_ff[IDX_W-1:0];
                        mem_wr_data   = {slots_used_ff[IDX_W-1:0], {GEN_BITS{1'b0}}};
                        slots_used_in = slots_used_ff + CNT_W'(1);
                        res_idx_in    = slots_used_ff[IDX_W-1:0];
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  REQ_REMOVE: begin
                     if (!idx_in_range || free_count_ff >= slots_used_ff) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        mem_wr_en     = 1'b1;
                        mem_addr      = req_slot_index;
                        mem_wr_data   = {(head_valid_ff ? head_idx_ff : {IDX_W{1'b0}}),
                                         req_slot_generation};
                        head_idx_in   = req_slot_index;
                        head_gen_in   = req_slot_generation;
                        head_valid_in = 1'b1;
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                  end
                  REQ_READ: begin
                     if (!idx_in_range) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        mem_rd_en = 1'b1;
                        mem_addr  = req_slot_index;
                        state_in  = ST_READ_DATA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP_LINK: begin
            mem_wr_en     = 1'b1;
            mem_addr      = head_idx_ff;
            mem_wr_data   = {head_idx_ff, head_gen_inc};
            res_idx_in    = head_idx_ff;
            res_gen_in    = head_gen_inc;
            free_count_in = count_dec;
            next_idx_in   = rd_link;
            if (count_dec != '0) begin
               state_in = ST_POP_NEXT;
            end else begin
               head_idx_in   = '0;
               head_gen_in   = '0;
               head_valid_in = 1'b0;
               state_in      = ST_FINISH;
            end
         end
         ST_POP_NEXT: begin
            mem_rd_en = 1'b1;
            mem_addr  = next_idx_ff;
            state_in  = ST_POP_GEN;
         end
         ST_POP_GEN: begin
            head_idx_in   = next_idx_ff;
            head_gen_in   = rd_gen;
            head_valid_in = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_READ_DATA: begin
            res_idx_in = rd_link;
            res_gen_in = rd_gen;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_index      = res_idx_ff;
   assign res_generation = res_gen_ff;
   assign res_status     = res_status_ff;
   assign res_free_slots = free_count_ff;

endmodule

@@ rtl/gha_out.sv @@
module gha_out
   import gha_pkg::*;
#(
   parameter int IDX_W = $clog2(CAPACITY_DEF),
   parameter int GEN_W = GEN_BITS_DEF,
   parameter int CNT_W = $clog2(CAPACITY_DEF + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   output logic             res_ready,
   input  logic [IDX_W-1:0] res_index,
   input  logic [GEN_W-1:0] res_generation,
   input  logic [1:0]       res_status,
   input  logic [CNT_W-1:0] res_free_slots,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [IDX_W-1:0] rsp_handle_index,
   output logic [GEN_W-1:0] rsp_handle_generation,
   output logic [1:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_free_slots
);

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] index_ff;
   logic [GEN_W-1:0] gen_ff;
   logic [1:0]       status_ff;
   logic [CNT_W-1:0] count_ff;
   logic             load;

   assign res_ready = !valid_ff || !rsp_stall;
   assign load      = res_valid && res_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff  <= res_index;
         gen_ff    <= res_generation;
         status_ff <= res_status;
         count_ff  <= res_free_slots;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_handle_index      = index_ff;
   assign rsp_handle_generation = gen_ff;
   assign rsp_status            = status_ff;
   assign rsp_free_slots        = count_ff;

endmodule

@@ rtl/generational_handle_allocator_core.sv @@
// Accept to rsp_valid: append, remove, error and unknown items pass ST_FINISH
// only; read passes ST_READ_DATA first; a create from the free list passes
// ST_POP_LINK, then ST_POP_NEXT and ST_POP_GEN unless it empties the free list,
// set by two dependent reads of the slot table. One item in flight; next item
// accepted in the cycle after the result enters the output register. Synchronous
// active-high reset clears counters and the free-list head, not the slot table.
module generational_handle_allocator_core
   import gha_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int GEN_BITS = GEN_BITS_DEF,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1),
   localparam int WORD_W = IDX_W + GEN_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [GEN_BITS-1:0] req_slot_generation,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_handle_index,
   output logic [GEN_BITS-1:0] rsp_handle_generation,
   output logic [1:0]          rsp_status,
   output logic [CNT_W-1:0]    rsp_free_slots
);

   logic                mem_wr_en;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_addr;
   logic [WORD_W-1:0]   mem_wr_data;
   logic [WORD_W-1:0]   mem_rd_data;
   logic                res_valid;
   logic                res_ready;
   logic [IDX_W-1:0]    res_index;
   logic [GEN_BITS-1:0] res_generation;
   logic [1:0]          res_status;
   logic [CNT_W-1:0]    res_free_slots;

   gha_ram #(
      .DEPTH  (CAPACITY),
      .WORD_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   gha_ctrl #(
      .CAPACITY (CAPACITY),
      .GEN_BITS (GEN_BITS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_slot_index      (req_slot_index),
      .req_slot_generation (req_slot_generation),
      .mem_wr_en           (mem_wr_en),
      .mem_rd_en           (mem_rd_en),
      .mem_addr            (mem_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_data         (mem_rd_data),
      .res_valid           (res_valid),
      .res_ready           (res_ready),
      .res_index           (res_index),
      .res_generation      (res_generation),
      .res_status          (res_status),
      .res_free_slots      (res_free_slots)
   );

   gha_out #(
      .IDX_W (IDX_W),
      .GEN_W (GEN_BITS),
      .CNT_W (CNT_W)
   ) u_out (
      .clock                 (clock),
      .reset                 (reset),
      .res_valid             (res_valid),
      .res_ready             (res_ready),
      .res_index             (res_index),
      .res_generation        (res_generation),
      .res_status            (res_status),
      .res_free_slots        (res_free_slots),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_handle_index      (rsp_handle_index),
      .rsp_handle_generation (rsp_handle_generation),
      .rsp_status            (rsp_status),
      .rsp_free_slots        (rsp_free_slots)
   );

endmodule

@@ test/handle_allocator_checker.sv @@
`timescale 1ns / 100ps
module handle_allocator_checker
   import gha_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int GEN_BITS = GEN_BITS_DEF,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [GEN_BITS-1:0] req_slot_generation,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [IDX_W-1:0]    rsp_handle_index,
   input  logic [GEN_BITS-1:0] rsp_handle_generation,
   input  logic [1:0]          rsp_status,
   input  logic [CNT_W-1:0]    rsp_free_slots,
   output int                  fail_count,
   output int                  outstanding
);

   typedef struct packed {
      logic [IDX_W-1:0]    index;
      logic [GEN_BITS-1:0] generation;
      logic [1:0]          status;
      logic [CNT_W-1:0]    free_slots;
   } handle_result_type;

   // shadow of the slot table: link (or own index) and generation per slot
   logic [IDX_W-1:0]    link_mem [CAPACITY];
   logic [GEN_BITS-1:0] gen_mem [CAPACITY];
   logic [CNT_W-1:0]    used_cnt;
   logic [CNT_W-1:0]    free_cnt;
   logic [IDX_W-1:0]    head_idx;
   logic [GEN_BITS-1:0] head_gen;
   logic                head_ok;

   handle_result_type expected_handles[$];
   int errors = 0;

   assign fail_count = errors;

   function automatic handle_result_type predict_handle_op(logic [1:0] code,
                                                           logic [IDX_W-1:0] idx,
                                                           logic [GEN_BITS-1:0] gen);
      handle_result_type r;
      logic [IDX_W-1:0] h;
      logic [IDX_W-1:0] nxt;
      logic [GEN_BITS-1:0] ng;
      r = '0;
      case (code)
         REQ_CREATE: begin
            if (head_ok && free_cnt != 0) begin
               h = head_idx;
               ng = head_gen + 1'b1;
               nxt = link_mem[h];
               link_mem[h] = h;
               gen_mem[h] = ng;
               free_cnt = free_cnt - 1'b1;
               if (free_cnt != 0) begin
                  head_idx = nxt;
                  head_gen = gen_mem[nxt];
                  head_ok = 1'b1;
               end else begin
                  head_idx = '0;
                  head_gen = '0;
                  head_ok = 1'b0;
               end
               r.index = h;
               r.generation = ng;
            end else if (used_cnt < CAPACITY) begin
               link_mem[used_cnt[IDX_W-1:0]] = used_cnt[IDX_W-1:0];
               gen_mem[used_cnt[IDX_W-1:0]] = '0;
               r.index = used_cnt[IDX_W-1:0];
               used_cnt = used_cnt + 1'b1;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         REQ_REMOVE: begin
            if (idx >= used_cnt || free_cnt >= used_cnt) begin
               r.status = STATUS_RANGE;
            end else begin
               link_mem[idx] = head_ok ? head_idx : '0;
               gen_mem[idx] = gen;
               head_idx = idx;
               head_gen = gen;
               head_ok = 1'b1;
               free_cnt = free_cnt + 1'b1;
            end
         end
         REQ_READ: begin
            if (idx >= used_cnt) begin
               r.status = STATUS_RANGE;
            end else begin
               r.index = link_mem[idx];
               r.generation = gen_mem[idx];
            end
         end
         default: ;
      endcase
      r.free_slots = free_cnt;
      return r;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      handle_result_type want;
      if (reset) begin
         used_cnt = '0;
         free_cnt = '0;
         head_idx = '0;
         head_gen = '0;
         head_ok = 1'b0;
         expected_handles.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_handles.size() == 0) begin
               $error("rsp item with no request outstanding");
               errors++;
            end else begin
               want = expected_handles.pop_front();
               check_field("handle_index", want.index, rsp_handle_index);
               check_field("handle_generation", want.generation, rsp_handle_generation);
               check_field("status", want.status, rsp_status);
               check_field("free_slots", want.free_slots, rsp_free_slots);
            end
         end
         if (req_valid && !req_stall)
            expected_handles.insert(expected_handles.size(),
                                    predict_handle_op(req_type, req_slot_index,
                                                      req_slot_generation));
      end
      outstanding = expected_handles.size();
   end

endmodule

@@ test/generational_handle_allocator_core_tb.sv @@
`timescale 1ns / 100ps
module generational_handle_allocator_core_tb
   import gha_pkg::*;
();

   localparam int IDX_W = $clog2(CAPACITY_DEF);
   localparam int CNT_W = $clog2(CAPACITY_DEF + 1);
   localparam int GEN_MAX = (1 << GEN_BITS_DEF) - 1;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0]        index;
      logic [GEN_BITS_DEF-1:0] generation;
   } handle_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_type;
   logic [IDX_W-1:0] req_slot_index;
   logic [GEN_BITS_DEF-1:0] req_slot_generation;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [IDX_W-1:0] rsp_handle_index;
   logic [GEN_BITS_DEF-1:0] rsp_handle_generation;
   logic [1:0] rsp_status;
   logic [CNT_W-1:0] rsp_free_slots;

   int fail_count;
   int outstanding;

   handle_type live_handles[$];
   logic [1:0] sent_types[$];
   logic [IDX_W-1:0] last_freed = '0;
   bit table_full = 1'b0;
   bit quiet = 1'b0;
   int idle_pct = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   always #6 clock = ~clock;

   generational_handle_allocator_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_slot_index        (req_slot_index),
      .req_slot_generation   (req_slot_generation),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_handle_index      (rsp_handle_index),
      .rsp_handle_generation (rsp_handle_generation),
      .rsp_status            (rsp_status),
      .rsp_free_slots        (rsp_free_slots)
   );

   handle_allocator_checker alloc_monitor (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_slot_index        (req_slot_index),
      .req_slot_generation   (req_slot_generation),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_handle_index      (rsp_handle_index),
      .rsp_handle_generation (rsp_handle_generation),
      .rsp_status            (rsp_status),
      .rsp_free_slots        (rsp_free_slots),
      .fail_count            (fail_count),
      .outstanding           (outstanding)
   );

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 99) < idle_pct)
            stall_left <= $urandom_range(1, 14);
      end
   end

   // track handed-out handles so removes mostly target live slots
   always @(posedge clock) begin
      logic [1:0] code;
      handle_type h;
      if (!reset && rsp_valid && !rsp_stall && sent_types.size() != 0) begin
         code = sent_types.pop_front();
         if (code == REQ_CREATE && rsp_status == STATUS_OK) begin
            h.index = rsp_handle_index;
            h.generation = rsp_handle_generation;
            live_handles.insert(live_handles.size(), h);
         end
         if (code == REQ_CREATE && rsp_status == STATUS_FULL)
            table_full = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] code, logic [IDX_W-1:0] idx,
                            logic [GEN_BITS_DEF-1:0] gen);
      if (items_sent % 64 == 0) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 6;
            default: idle_pct = 25;
         endcase
      end
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_slot_index <= idx;
      req_slot_generation <= gen;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_types.insert(sent_types.size(), code);
      items_sent++;
   endtask

   function automatic logic [IDX_W-1:0] any_index();
      return IDX_W'($urandom_range(0, CAPACITY_DEF - 1));
   endfunction

   function automatic logic [GEN_BITS_DEF-1:0] any_gen();
      return GEN_BITS_DEF'($urandom_range(0, GEN_MAX));
   endfunction

   task automatic random_item(int create_pct, int remove_pct, int read_pct);
      int r;
      int k;
      handle_type h;
      r = $urandom_range(0, 99);
      if (r < create_pct) begin
         send_item(REQ_CREATE, any_index(), any_gen());
      end else if (r < create_pct + remove_pct) begin
         k = $urandom_range(0, 9);
         if (k < 8 && live_handles.size() != 0) begin
            k = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[k];
            live_handles.delete(k);
            if ($urandom_range(0, 5) == 0)
               h.generation = any_gen();
            last_freed = h.index;
            send_item(REQ_REMOVE, h.index, h.generation);
         end else if (k == 8) begin
            // double free
            send_item(REQ_REMOVE, last_freed, any_gen());
         end else begin
            send_item(REQ_REMOVE, any_index(), any_gen());
         end
      end else if (r < create_pct + remove_pct + read_pct) begin
         k = $urandom_range(0, 5);
         if (k < 3 && live_handles.size() != 0)
            send_item(REQ_READ, live_handles[$urandom_range(0, live_handles.size() - 1)].index,
                      any_gen());
         else if (k < 5)
            send_item(REQ_READ, last_freed, any_gen());
         else
            send_item(REQ_READ, any_index(), any_gen());
      end else begin
         send_item(REQ_UNKNOWN, any_index(), any_gen());
      end
   endtask

   initial begin
      int n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_CREATE;
      req_slot_index <= '0;
      req_slot_generation <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table, then a short list walk with generation wrap
      send_item(REQ_READ, '0, '0);
      send_item(REQ_REMOVE, '0, '0);
      send_item(REQ_CREATE, '0, '0);
      send_item(REQ_CREATE, '1, '1);
      send_item(REQ_CREATE, '0, '0);
      send_item(REQ_READ, 10'd1, '0);
      send_item(REQ_REMOVE, 10'd1, 8'hFF);
      send_item(REQ_READ, 10'd1, '0);
      send_item(REQ_REMOVE, 10'd0, 8'd3);
      send_item(REQ_REMOVE, 10'd2, 8'h80);
      send_item(REQ_REMOVE, 10'd1, 8'd9);
      send_item(REQ_CREATE, '0, '0);
      send_item(REQ_CREATE, '0, '0);
      send_item(REQ_CREATE, '1, '1);
      send_item(REQ_CREATE, '0, '0);
      send_item(REQ_REMOVE, '1, '1);
      send_item(REQ_READ, '1, '1);
      send_item(REQ_UNKNOWN, '1, '1);
      send_item(REQ_UNKNOWN, '0, '0);
      send_item(REQ_READ, 10'd2, '0);
      send_item(REQ_REMOVE, 10'd3, '0);
      send_item(REQ_READ, 10'd3, '0);
      send_item(REQ_CREATE, '0, '0);

      for (n = 0; n < 350; n++)
         random_item(45, 30, 20);

      // fill the table
      n = 0;
      while (!table_full && n < 2000) begin
         random_item(92, 0, 8);
         n++;
      end
      repeat (6) send_item(REQ_CREATE, any_index(), any_gen());
      send_item(REQ_READ, '1, any_gen());
      send_item(REQ_REMOVE, '1, any_gen());

      quiet = 1'b1;
      for (n = 0; n < 120; n++)
         random_item(30, 45, 20);
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
